// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files of the two-queue priority server.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error("%m: property violated");
// Check that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rstn_s, expr)
`endif
`endif

// ===== sv/tqps_pkg.sv =====
// Shared types and constants of the two-queue priority server.
package tqps_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 16;
  localparam int TAG_W           = 16;  // width of request_tag and served_tag
  localparam int CNT_OUT_W       = 5;   // width of high_count and low_count

  typedef enum logic [1:0] {
    FN_ENQ_HIGH = 2'd0,
    FN_ENQ_LOW  = 2'd1,
    FN_SERVE    = 2'd2,
    FN_PROMOTE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OC_OK        = 2'd0,
    OC_EMPTY     = 2'd1,
    OC_NOT_FOUND = 2'd2,
    OC_FULL      = 2'd3
  } outcome_t;

  // Per-cycle command from the control logic to one queue and its cells.
  typedef struct packed {
    logic push;     // append tag at the rear
    logic pop;      // drop the front entry
    logic promote;  // move first matching entry to the front
  } q_ctl_t;

endpackage

// ===== sv/tqps_cell.sv =====
// One storage cell of a queue: holds a tag, shifts with its neighbors, matches tags.
module tqps_cell #(
  parameter int TAG_BITS = 16,
  parameter int CNT_W    = 5,
  parameter int IDX      = 0
) (
  input  logic                clk,
  input  tqps_pkg::q_ctl_t    ctl,
  input  logic [CNT_W-1:0]    count,
  input  logic [TAG_BITS-1:0] tag_in,
  input  logic [TAG_BITS-1:0] left_tag,
  input  logic [TAG_BITS-1:0] right_tag,
  input  logic                found_in,
  input  logic                found_all,
  output logic                found_out,
  output logic [TAG_BITS-1:0] tag_o
);
  import tqps_pkg::*;

  logic [TAG_BITS-1:0] tag_r;
  logic [TAG_BITS-1:0] tag_nxt;
  logic                occupied;
  logic                hit;

  assign occupied  = count > CNT_W'(IDX);
  assign hit       = occupied && (tag_r == tag_in);
  assign found_out = found_in | hit;
  assign tag_o     = tag_r;

  always_comb begin
    tag_nxt = tag_r;
    if (ctl.push && (count == CNT_W'(IDX))) begin
      tag_nxt = tag_in;
    end else if (ctl.pop) begin
      tag_nxt = right_tag;
    end else if (ctl.promote && found_all && !found_in) begin
      // cells up to and including the match move one place toward the rear
      tag_nxt = left_tag;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

endmodule

// ===== sv/tqps_queue.sv =====
// Queue built as a row of shifting tag cells with an occupancy counter.
`include "assert_macros.svh"
module tqps_queue #(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16,
  parameter int CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tqps_pkg::q_ctl_t    ctl,
  input  logic [TAG_BITS-1:0] tag_in,
  output logic [TAG_BITS-1:0] head,
  output logic [CNT_W-1:0]    count,
  output logic [CNT_W-1:0]    count_nxt,
  output logic                full,
  output logic                found
);
  import tqps_pkg::*;

  logic [CNT_W-1:0]    count_r;
  logic [TAG_BITS-1:0] tags  [DEPTH];
  logic                chain [DEPTH+1];

  assign chain[0] = 1'b0;
  assign found    = chain[DEPTH];
  assign head     = tags[0];
  assign count    = count_r;
  assign full     = count_r == CNT_W'(DEPTH);

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic [TAG_BITS-1:0] left_s;
    logic [TAG_BITS-1:0] right_s;

    // the front cell takes the promoted tag itself, the last cell takes zero
    if (j == 0) begin : g_front
      assign left_s = tag_in;
    end else begin : g_mid_l
      assign left_s = tags[j-1];
    end
    if (j == DEPTH - 1) begin : g_rear
      assign right_s = '0;
    end else begin : g_mid_r
      assign right_s = tags[j+1];
    end

    tqps_cell #(
      .TAG_BITS(TAG_BITS),
      .CNT_W   (CNT_W),
      .IDX     (j)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (count_r),
      .tag_in   (tag_in),
      .left_tag (left_s),
      .right_tag(right_s),
      .found_in (chain[j]),
      .found_all(found),
      .found_out(chain[j+1]),
      .tag_o    (tags[j])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.push && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.pop && (count_r != '0)) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  `ASSERT_NEVER(a_count_bound, clk, rst_n, count_r > CNT_W'(DEPTH))
  `ASSERT_NEVER(a_pop_empty, clk, rst_n, ctl.pop && (count_r == '0))
  `ASSERT_PROP(a_promote_front, clk, rst_n,
               (ctl.promote && found) |=> (head == $past(tag_in)))

endmodule

// ===== sv/two_queue_priority_server_top.sv =====
// Top level of the two-queue priority server: command decode and result register.
//
// The server keeps a high-priority FIFO and a low-priority deque of request tags,
// QUEUE_DEPTH entries each. Every input transaction (in_tuser = func) enqueues a
// tag, serves one entry (FIFO first, then the deque front) or promotes the first
// matching deque entry to the front, and yields exactly one result transaction.
// When an item is accepted, the queues update and the result is loaded into the
// output register at the same edge; a new item is taken every cycle as long as the
// result register is free or being drained. The longest path is the tag compare
// and found chain across the deque's cells.
`include "assert_macros.svh"
module two_queue_priority_server_top #(
  parameter int QUEUE_DEPTH = tqps_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = tqps_pkg::TAG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] request_tag
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [0] served_valid, [16:1] served_tag,
                                  // [17] served_from, [22:18] high_count,
                                  // [27:23] low_count, [31:28] zero
  output logic [1:0]  out_tuser   // [1:0] outcome
);
  import tqps_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                accept;
  logic [TAG_BITS-1:0] tag_in;
  logic [TAG_W+TAG_BITS-1:0] tag_ext;
  q_ctl_t              hi_ctl, lo_ctl;
  logic [TAG_BITS-1:0] hi_head, lo_head;
  logic [CNT_W-1:0]    hi_cnt, lo_cnt, hi_cnt_nxt, lo_cnt_nxt;
  logic                hi_full, lo_full, hi_found, lo_found;

  logic                sv_nxt, from_nxt;
  logic [TAG_BITS-1:0] stag_nxt;
  outcome_t            oc_nxt;

  logic                out_tvalid_r;
  logic                sv_r, from_r;
  logic [TAG_BITS-1:0] stag_r;
  outcome_t            oc_r;
  logic [CNT_W-1:0]    hi_cnt_r, lo_cnt_r;

  logic [TAG_BITS+TAG_W-1:0]     stag_ext;
  logic [CNT_W+CNT_OUT_W-1:0]    hi_cnt_ext, lo_cnt_ext;

  assign in_tready = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign tag_ext   = {{TAG_BITS{1'b0}}, in_tdata};
  assign tag_in    = tag_ext[TAG_BITS-1:0];

  always_comb begin
    hi_ctl   = '0;
    lo_ctl   = '0;
    sv_nxt   = 1'b0;
    from_nxt = 1'b0;
    stag_nxt = '0;
    oc_nxt   = OC_OK;
    case (func_t'(in_tuser))
      FN_ENQ_HIGH: begin
        if (hi_full) oc_nxt = OC_FULL;
        else         hi_ctl.push = accept;
      end
      FN_ENQ_LOW: begin
        if (lo_full) oc_nxt = OC_FULL;
        else         lo_ctl.push = accept;
      end
      FN_SERVE: begin
        if (hi_cnt != '0) begin
          hi_ctl.pop = accept;
          sv_nxt     = 1'b1;
          stag_nxt   = hi_head;
        end else if (lo_cnt != '0) begin
          lo_ctl.pop = accept;
          sv_nxt     = 1'b1;
          stag_nxt   = lo_head;
          from_nxt   = 1'b1;
        end else begin
          oc_nxt = OC_EMPTY;
        end
      end
      FN_PROMOTE: begin
        lo_ctl.promote = accept;
        if (!lo_found) oc_nxt = OC_NOT_FOUND;
      end
      default: begin
        oc_nxt = OC_OK;
      end
    endcase
  end

  tqps_queue #(
    .DEPTH   (QUEUE_DEPTH),
    .TAG_BITS(TAG_BITS),
    .CNT_W   (CNT_W)
  ) u_high (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (hi_ctl),
    .tag_in   (tag_in),
    .head     (hi_head),
    .count    (hi_cnt),
    .count_nxt(hi_cnt_nxt),
    .full     (hi_full),
    .found    (hi_found)
  );

  tqps_queue #(
    .DEPTH   (QUEUE_DEPTH),
    .TAG_BITS(TAG_BITS),
    .CNT_W   (CNT_W)
  ) u_low (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (lo_ctl),
    .tag_in   (tag_in),
    .head     (lo_head),
    .count    (lo_cnt),
    .count_nxt(lo_cnt_nxt),
    .full     (lo_full),
    .found    (lo_found)
  );

  // Hold the result until the transaction completes downstream.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (accept) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sv_r     <= sv_nxt;
      from_r   <= from_nxt;
      stag_r   <= stag_nxt;
      oc_r     <= oc_nxt;
      hi_cnt_r <= hi_cnt_nxt;
      lo_cnt_r <= lo_cnt_nxt;
    end
  end

  assign stag_ext   = {{TAG_W{1'b0}}, stag_r};
  assign hi_cnt_ext = {{CNT_OUT_W{1'b0}}, hi_cnt_r};
  assign lo_cnt_ext = {{CNT_OUT_W{1'b0}}, lo_cnt_r};

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = oc_r;
  assign out_tdata  = {4'b0000, lo_cnt_ext[CNT_OUT_W-1:0], hi_cnt_ext[CNT_OUT_W-1:0],
                       from_r, stag_ext[TAG_W-1:0], sv_r};

  `ASSERT_PROP(a_result_follows, clk, rst_n, accept |=> out_tvalid)
  `ASSERT_NEVER(a_served_not_ok, clk, rst_n, out_tvalid && sv_r && (oc_r != OC_OK))
  `ASSERT_NEVER(a_both_popped, clk, rst_n, hi_ctl.pop && lo_ctl.pop)
  `ASSERT_NEVER(a_promote_high, clk, rst_n, hi_ctl.promote || (hi_found && 1'b0))

endmodule
